// ===== design/double_ended_queue_top_assert.svh =====
// Assertion macros used by the deque top level.
`ifndef DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DEQ_ASSERT_IMPLY(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("deque check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define DEQ_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("deque check failed: next-cycle implication");

`endif

// ===== design/deq_pkg.sv =====
// Types and constants shared by the deque cells, rows and top level.
`timescale 1ns / 1ps

package deq_pkg;

	localparam int KIND_W = 2;
	localparam int WORD_W = 32;
	localparam int OCC_W  = 5;

	// Operation requested by one input transfer
	typedef enum logic [KIND_W-1:0] {
		KIND_PUSH_FRONT = 2'd0,
		KIND_PUSH_BACK  = 2'd1,
		KIND_POP_FRONT  = 2'd2,
		KIND_POP_BACK   = 2'd3
	} kind_t;

	// Result status
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_OVERFLOW  = 2'd2
	} status_t;

	// What a cell loads this cycle
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_TAKE_LEFT,
		CELL_TAKE_RIGHT
	} cell_op_t;

	// Row command: near end is cell 0, far end is the first free cell
	typedef struct packed {
		logic near_push;
		logic far_push;
		logic near_pop;
	} row_cmd_t;

endpackage

// ===== design/deq_cell.sv =====
// One storage cell of a deque row: holds a word and trades it with its neighbors.
`timescale 1ns / 1ps

module deq_cell #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  deq_pkg::cell_op_t     op,
	input  logic [DATA_WIDTH-1:0] load_word,
	input  logic [DATA_WIDTH-1:0] left_word,
	input  logic [DATA_WIDTH-1:0] right_word,
	output logic [DATA_WIDTH-1:0] word
);

	logic [DATA_WIDTH-1:0] word_q;
	logic [DATA_WIDTH-1:0] word_d;

	// next word select
	always_comb begin
		case (op)
			deq_pkg::CELL_LOAD:       word_d = load_word;
			deq_pkg::CELL_TAKE_LEFT:  word_d = left_word;
			deq_pkg::CELL_TAKE_RIGHT: word_d = right_word;
			default:                  word_d = word_q;
		endcase
	end

	always_ff @(posedge clk) begin
		word_q <= word_d;
	end

	assign word = word_q;

endmodule

// ===== design/deq_row.sv =====
// A row of deque cells aligned to one end; entries fill cells 0 .. count-1.
`timescale 1ns / 1ps

module deq_row #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32,
	parameter int CW         = $clog2(DEPTH + 1)
) (
	input  logic                  clk,
	input  deq_pkg::row_cmd_t     cmd,
	input  logic [CW-1:0]         count,
	input  logic [DATA_WIDTH-1:0] push_word,
	output logic [DATA_WIDTH-1:0] near_word
);

	logic [DATA_WIDTH-1:0] cell_word [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		deq_pkg::cell_op_t     op;
		logic [DATA_WIDTH-1:0] left_w;
		logic [DATA_WIDTH-1:0] right_w;

		assign left_w  = (i == 0) ? push_word : cell_word[(i == 0) ? 0 : i - 1];
		assign right_w = (i == DEPTH - 1) ? cell_word[i] :
		                 cell_word[(i == DEPTH - 1) ? i : i + 1];

		// per-cell decode: near push shifts away, near pop shifts in, far push lands at count
		always_comb begin
			op = deq_pkg::CELL_HOLD;
			if (cmd.near_push) begin
				op = (i == 0) ? deq_pkg::CELL_LOAD : deq_pkg::CELL_TAKE_LEFT;
			end else if (cmd.near_pop) begin
				op = (i == DEPTH - 1) ? deq_pkg::CELL_HOLD : deq_pkg::CELL_TAKE_RIGHT;
			end else if (cmd.far_push && (count == CW'(i))) begin
				op = deq_pkg::CELL_LOAD;
			end
		end

		deq_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk        (clk),
			.op         (op),
			.load_word  (push_word),
			.left_word  (left_w),
			.right_word (right_w),
			.word       (cell_word[i])
		);
	end

	assign near_word = cell_word[0];

endmodule

// ===== design/double_ended_queue_top.sv =====
// Bounded double-ended queue built from two rows of shifting cells.
//
// One transfer is taken per clock: an input transfer is accepted whenever the
// result register is empty or its result leaves in the same cycle, and each
// operation completes in the cycle that accepts it, with its result presented
// on the following cycle. Storage is two rows of DEPTH cells holding the same
// entries, one aligned to the front and one to the back, so the front and
// back words always sit in cell 0 of a row. A push at one end shifts that
// end's row by one cell and writes the other row at the count's cell; a pop
// shifts only that end's row. No clearing pass runs after reset; cells beyond
// the count are never read. Occupancy reports the low five bits of the count.
`timescale 1ns / 1ps

`include "double_ended_queue_top_assert.svh"

module double_ended_queue_top #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [deq_pkg::KIND_W-1:0]   kind,
	input  logic [deq_pkg::WORD_W-1:0]   data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [deq_pkg::WORD_W-1:0]   popped,
	output logic [deq_pkg::WORD_W-1:0]   front_word,
	output logic [deq_pkg::WORD_W-1:0]   back_word,
	output logic                         is_empty,
	output logic [deq_pkg::OCC_W-1:0]    occupancy,
	output logic [1:0]                   status
);

	localparam int CW = $clog2(DEPTH + 1);

	logic                  out_valid_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         count_d;
	deq_pkg::status_t      status_q;
	deq_pkg::status_t      status_d;
	logic [DATA_WIDTH-1:0] popped_q;
	logic [DATA_WIDTH-1:0] popped_d;

	logic                  in_acc;
	deq_pkg::kind_t        op_kind;
	logic                  is_push;
	logic                  full;
	logic                  empty;
	logic                  do_op;
	logic [DATA_WIDTH-1:0] push_word;
	logic [DATA_WIDTH-1:0] front_near;
	logic [DATA_WIDTH-1:0] back_near;
	deq_pkg::row_cmd_t     cmd_front;
	deq_pkg::row_cmd_t     cmd_back;

	// input transfer handshake
	assign in_stall = out_valid_q && out_stall;
	assign in_acc   = in_valid && !in_stall;

	assign op_kind   = deq_pkg::kind_t'(kind);
	assign is_push   = (op_kind == deq_pkg::KIND_PUSH_FRONT) ||
	                   (op_kind == deq_pkg::KIND_PUSH_BACK);
	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign do_op     = in_acc && (is_push ? !full : !empty);
	assign push_word = DATA_WIDTH'(data);

	// row commands: the back row sees front and back swapped
	always_comb begin
		cmd_front.near_push = do_op && (op_kind == deq_pkg::KIND_PUSH_FRONT);
		cmd_front.far_push  = do_op && (op_kind == deq_pkg::KIND_PUSH_BACK);
		cmd_front.near_pop  = do_op && (op_kind == deq_pkg::KIND_POP_FRONT);
		cmd_back.near_push  = do_op && (op_kind == deq_pkg::KIND_PUSH_BACK);
		cmd_back.far_push   = do_op && (op_kind == deq_pkg::KIND_PUSH_FRONT);
		cmd_back.near_pop   = do_op && (op_kind == deq_pkg::KIND_POP_BACK);
	end

	deq_row #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH),
		.CW         (CW)
	) u_front_row (
		.clk       (clk),
		.cmd       (cmd_front),
		.count     (count_q),
		.push_word (push_word),
		.near_word (front_near)
	);

	deq_row #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH),
		.CW         (CW)
	) u_back_row (
		.clk       (clk),
		.cmd       (cmd_back),
		.count     (count_q),
		.push_word (push_word),
		.near_word (back_near)
	);

	// count, status and popped word for this transfer
	always_comb begin
		count_d  = count_q;
		status_d = deq_pkg::ST_OK;
		popped_d = '0;
		if (is_push) begin
			if (full) begin
				status_d = deq_pkg::ST_OVERFLOW;
			end else begin
				count_d = count_q + CW'(1);
			end
		end else begin
			if (empty) begin
				status_d = deq_pkg::ST_UNDERFLOW;
			end else begin
				count_d  = count_q - CW'(1);
				popped_d = (op_kind == deq_pkg::KIND_POP_FRONT) ? front_near : back_near;
			end
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			count_q     <= '0;
			status_q    <= deq_pkg::ST_OK;
		end else begin
			if (in_acc) begin
				out_valid_q <= 1'b1;
				count_q     <= count_d;
				status_q    <= status_d;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// popped word register
	always_ff @(posedge clk) begin
		if (in_acc) begin
			popped_q <= popped_d;
		end
	end

	// result fields come straight from state, which holds while stalled
	assign out_valid  = out_valid_q;
	assign popped     = deq_pkg::WORD_W'(popped_q);
	assign front_word = empty ? '0 : deq_pkg::WORD_W'(front_near);
	assign back_word  = empty ? '0 : deq_pkg::WORD_W'(back_near);
	assign is_empty   = empty;
	assign occupancy  = deq_pkg::OCC_W'(count_q);
	assign status     = status_q;

	// checks
	`DEQ_ASSERT_IMPLY(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(DEPTH))
	`DEQ_ASSERT_IMPLY(a_single_entry_rows_agree, clk, arst_n, count_q == CW'(1), front_near == back_near)
	`DEQ_ASSERT_NEXT(a_overflow_drops, clk, arst_n, in_acc && is_push && full, (count_q == $past(count_q)) && (status_q == deq_pkg::ST_OVERFLOW))
	`DEQ_ASSERT_NEXT(a_underflow_holds, clk, arst_n, in_acc && !is_push && empty, (count_q == '0) && (status_q == deq_pkg::ST_UNDERFLOW) && (popped_q == '0))

endmodule
